>>> hdl/bihv_pkg.sv
// ----------------------------------------------------------------------------
// bihv_pkg
// Types and codes shared by the boot image health validator modules.
// ----------------------------------------------------------------------------
package bihv_pkg;

  localparam logic [31:0] DelayResetMs = 32'd60000;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_CONFIRM = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    IMG_UNDEFINED = 3'd0,
    IMG_NEW       = 3'd1,
    IMG_PENDING   = 3'd2,
    IMG_VALID     = 3'd3,
    IMG_INVALID   = 3'd4,
    IMG_ABORTED   = 3'd5
  } img_e;

  typedef enum logic [2:0] {
    PH_NOT_STARTED   = 3'd0,
    PH_NOT_PENDING   = 3'd1,
    PH_WAITING       = 3'd2,
    PH_AWAIT_PERSIST = 3'd3,
    PH_CONFIRMED     = 3'd4,
    PH_ROLLBACK      = 3'd5,
    PH_PLAT_ERR      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_PLATFORM = 3'd1,
    ERR_READ     = 3'd2,
    ERR_HARD     = 3'd3,
    ERR_CONFIRM  = 3'd4,
    ERR_ROLLBACK = 3'd5
  } err_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] now_ms;
    logic        platform_present;
    logic        image_read_ok;
    logic [2:0]  image_state;
    logic        gates_ready;
    logic        hard_failure;
    logic        action_ok;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  phase;
    logic [2:0]  error_code;
    logic        rollback_request;
    logic        confirm_request;
    logic [31:0] remaining_ms;
  } out_item_t;

endpackage

>>> hdl/bihv_in_reg.sv
// ----------------------------------------------------------------------------
// bihv_in_reg
// Input register stage: captures one transaction and holds it until the
// step logic consumes it.
// ----------------------------------------------------------------------------
module bihv_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               advance_i,
  input  bihv_pkg::in_item_t item_i,
  output logic               valid_o,
  output bihv_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  bihv_pkg::in_item_t item_q;

  assign valid_d = load_i | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/bihv_engine.sv
// ----------------------------------------------------------------------------
// bihv_engine
// Validation state, delay register, single-pass step logic and result
// register.
// ----------------------------------------------------------------------------
module bihv_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                step_i,
  input  bihv_pkg::in_item_t  item_i,
  input  logic                out_valid_i,
  output bihv_pkg::out_item_t result_o
);

  logic [31:0]         delay_q;
  bihv_pkg::phase_e    phase_q, phase_d;
  bihv_pkg::err_e      error_q, error_d;
  logic [63:0]         since_q, since_d;
  logic                started_q, started_d;
  bihv_pkg::out_item_t result_q, result_d;

  logic [63:0] since_eff;
  logic [63:0] elapsed;
  logic        win_done;
  logic        ok;
  logic        rb_req;
  logic        cf_req;
  logic [31:0] remaining;

  assign since_eff = started_q ? since_q : item_i.now_ms;
  assign elapsed   = item_i.now_ms - since_eff;
  assign win_done  = elapsed >= {32'd0, delay_q};

  always_comb begin
    phase_d   = phase_q;
    error_d   = error_q;
    since_d   = since_q;
    started_d = started_q;
    ok        = 1'b0;
    rb_req    = 1'b0;
    cf_req    = 1'b0;
    unique case (item_i.command)
      bihv_pkg::CMD_START: begin
        since_d   = 64'd0;
        started_d = 1'b0;
        error_d   = bihv_pkg::ERR_NONE;
        priority if (!item_i.platform_present) begin
          phase_d = bihv_pkg::PH_PLAT_ERR;
          error_d = bihv_pkg::ERR_PLATFORM;
        end else if (!item_i.image_read_ok) begin
          phase_d = bihv_pkg::PH_PLAT_ERR;
          error_d = bihv_pkg::ERR_READ;
        end else if (item_i.image_state == bihv_pkg::IMG_PENDING) begin
          phase_d = bihv_pkg::PH_WAITING;
          ok      = 1'b1;
        end else if (item_i.image_state == bihv_pkg::IMG_VALID ||
                     item_i.image_state == bihv_pkg::IMG_UNDEFINED) begin
          phase_d = bihv_pkg::PH_NOT_PENDING;
          ok      = 1'b1;
        end else begin
          phase_d = bihv_pkg::PH_PLAT_ERR;
          error_d = bihv_pkg::ERR_READ;
        end
      end
      bihv_pkg::CMD_POLL: begin
        priority if (phase_q != bihv_pkg::PH_WAITING &&
                     phase_q != bihv_pkg::PH_AWAIT_PERSIST) begin
          ok = (phase_q == bihv_pkg::PH_NOT_PENDING) ||
               (phase_q == bihv_pkg::PH_CONFIRMED);
        end else if (item_i.hard_failure) begin
          rb_req = 1'b1;
          if (item_i.action_ok) begin
            phase_d = bihv_pkg::PH_ROLLBACK;
            error_d = bihv_pkg::ERR_HARD;
          end else begin
            phase_d = bihv_pkg::PH_PLAT_ERR;
            error_d = bihv_pkg::ERR_ROLLBACK;
          end
        end else if (phase_q == bihv_pkg::PH_AWAIT_PERSIST) begin
          ok = 1'b1;
        end else if (!item_i.gates_ready) begin
          since_d   = 64'd0;
          started_d = 1'b0;
          ok        = 1'b1;
        end else begin
          since_d   = since_eff;
          started_d = 1'b1;
          ok        = 1'b1;
          if (win_done) begin
            phase_d = bihv_pkg::PH_AWAIT_PERSIST;
          end
        end
      end
      bihv_pkg::CMD_CONFIRM: begin
        if (phase_q != bihv_pkg::PH_AWAIT_PERSIST) begin
          ok = (phase_q == bihv_pkg::PH_CONFIRMED);
        end else begin
          cf_req = 1'b1;
          if (item_i.action_ok) begin
            phase_d = bihv_pkg::PH_CONFIRMED;
            error_d = bihv_pkg::ERR_NONE;
            ok      = 1'b1;
          end else begin
            phase_d = bihv_pkg::PH_PLAT_ERR;
            error_d = bihv_pkg::ERR_CONFIRM;
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // since_d equals since_eff whenever the window is open in the waiting phase
  always_comb begin
    priority if (phase_d != bihv_pkg::PH_WAITING) begin
      remaining = 32'd0;
    end else if (!started_d) begin
      remaining = delay_q;
    end else if (win_done) begin
      remaining = 32'd0;
    end else begin
      remaining = delay_q - elapsed[31:0];
    end
  end

  always_comb begin
    result_d                  = '0;
    result_d.ok               = ok;
    result_d.phase            = phase_d;
    result_d.error_code       = error_d;
    result_d.rollback_request = rb_req;
    result_d.confirm_request  = cf_req;
    result_d.remaining_ms     = remaining;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= bihv_pkg::DelayResetMs;
      phase_q   <= bihv_pkg::PH_NOT_STARTED;
      error_q   <= bihv_pkg::ERR_NONE;
      since_q   <= 64'd0;
      started_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        delay_q <= cfg_data_i;
      end
      if (step_i) begin
        phase_q   <= phase_d;
        error_q   <= error_d;
        since_q   <= since_d;
        started_q <= started_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

`ifndef ASSERT_OFF
  a_closed_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> since_q == 64'd0)
    else $error("health window closed but start time not cleared");

  a_confirmed_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bihv_pkg::PH_CONFIRMED || phase_q == bihv_pkg::PH_NOT_PENDING)
      |-> error_q == bihv_pkg::ERR_NONE)
    else $error("error recorded in a healthy phase");

  a_remaining_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && result_q.remaining_ms != 32'd0)
      |-> result_q.phase == bihv_pkg::PH_WAITING)
    else $error("remaining time reported outside waiting phase");

  a_rollback_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && result_q.rollback_request)
      |-> (result_q.phase == bihv_pkg::PH_ROLLBACK ||
           result_q.phase == bihv_pkg::PH_PLAT_ERR))
    else $error("rollback request without rollback outcome");

  a_confirm_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && result_q.confirm_request)
      |-> (result_q.phase == bihv_pkg::PH_CONFIRMED ||
           result_q.phase == bihv_pkg::PH_PLAT_ERR))
    else $error("confirm request without confirm outcome");
`endif

endmodule

>>> hdl/boot_image_health_validator.sv
// ----------------------------------------------------------------------------
// boot_image_health_validator
// Supervises validation of an updated firmware image: start, health polling
// with a timed window, rollback on hard failure and confirmation.
// ----------------------------------------------------------------------------
// Takes one command transaction per cycle while the output is not stalled.
// After acceptance the transaction sits in the input register while the
// single-pass step logic (one 64-bit subtraction and compare against
// delay_ms) computes the value that the result register loads. A stalled
// output holds both stages; the input register still accepts a new
// transaction when its current one moves on in the same cycle. The delay
// register takes a write in every cycle.
module boot_image_health_validator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bihv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bihv_pkg::out_item_t out_data_o
);

  logic               s1_valid;
  bihv_pkg::in_item_t s1_item;
  logic               s1_advance;
  logic               in_accept;
  logic               out_valid_q, out_valid_d;

  assign s1_advance  = s1_valid & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid | s1_advance;
  assign in_accept   = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_d = s1_advance | (out_valid_q & ~out_ready_i);

  bihv_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_accept),
    .advance_i (s1_advance),
    .item_i    (in_data_i),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  bihv_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (s1_advance),
    .item_i      (s1_item),
    .out_valid_i (out_valid_q),
    .result_o    (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> test/boot_image_health_validator_tb.sv
// ----------------------------------------------------------------------------
// boot_image_health_validator_tb
// Self-checking bench for the boot image health validator. A verdict ledger
// mirrors the start, poll and confirm behaviour, including the health window
// and the wrapping time arithmetic. It predicts one verdict per accepted
// command and compares each returned transaction field by field. Stimulus is
// a short directed run, then validation sessions with random timing and
// content mixed with noise. The sessions run under several delay settings and
// random idling on both channels, with long receiver hold-offs and full
// drains.
// ----------------------------------------------------------------------------
module boot_image_health_validator_tb;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0] IMG_SPARE_LO = 3'd6;
  localparam logic [2:0] IMG_SPARE_HI = 3'd7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PhaseItems  = 117;

  class verdict_ledger;
    logic [31:0]         delay_ms;
    bihv_pkg::phase_e    phase;
    bihv_pkg::err_e      fault;
    logic [63:0]         healthy_since;
    bit                  window_open;
    bihv_pkg::out_item_t verdicts_due[$];
    int unsigned         errors;

    function new();
      delay_ms      = bihv_pkg::DelayResetMs;
      phase         = bihv_pkg::PH_NOT_STARTED;
      fault         = bihv_pkg::ERR_NONE;
      healthy_since = '0;
      window_open   = 1'b0;
      errors        = 0;
    endfunction

    function logic [31:0] window_left(logic [63:0] now);
      logic [63:0] elapsed;
      if (phase != bihv_pkg::PH_WAITING) return '0;
      if (!window_open) return delay_ms;
      elapsed = now - healthy_since;
      if (elapsed >= {32'd0, delay_ms}) return '0;
      return delay_ms - elapsed[31:0];
    endfunction

    function void note_command(bihv_pkg::in_item_t c);
      bihv_pkg::out_item_t v;
      v = '0;
      case (c.command)
        bihv_pkg::CMD_START: begin
          healthy_since = '0;
          window_open   = 1'b0;
          fault         = bihv_pkg::ERR_NONE;
          if (!c.platform_present) begin
            phase = bihv_pkg::PH_PLAT_ERR;
            fault = bihv_pkg::ERR_PLATFORM;
          end else if (!c.image_read_ok) begin
            phase = bihv_pkg::PH_PLAT_ERR;
            fault = bihv_pkg::ERR_READ;
          end else if (c.image_state == bihv_pkg::IMG_PENDING) begin
            phase = bihv_pkg::PH_WAITING;
            v.ok  = 1'b1;
          end else if (c.image_state == bihv_pkg::IMG_VALID ||
                       c.image_state == bihv_pkg::IMG_UNDEFINED) begin
            phase = bihv_pkg::PH_NOT_PENDING;
            v.ok  = 1'b1;
          end else begin
            phase = bihv_pkg::PH_PLAT_ERR;
            fault = bihv_pkg::ERR_READ;
          end
        end
        bihv_pkg::CMD_POLL: begin
          if (phase != bihv_pkg::PH_WAITING && phase != bihv_pkg::PH_AWAIT_PERSIST) begin
            v.ok = (phase == bihv_pkg::PH_NOT_PENDING || phase == bihv_pkg::PH_CONFIRMED);
          end else if (c.hard_failure) begin
            v.rollback_request = 1'b1;
            if (c.action_ok) begin
              phase = bihv_pkg::PH_ROLLBACK;
              fault = bihv_pkg::ERR_HARD;
            end else begin
              phase = bihv_pkg::PH_PLAT_ERR;
              fault = bihv_pkg::ERR_ROLLBACK;
            end
          end else if (phase == bihv_pkg::PH_AWAIT_PERSIST) begin
            v.ok = 1'b1;
          end else if (!c.gates_ready) begin
            healthy_since = '0;
            window_open   = 1'b0;
            v.ok          = 1'b1;
          end else begin
            if (!window_open) begin
              healthy_since = c.now_ms;
              window_open   = 1'b1;
            end
            if (c.now_ms - healthy_since >= {32'd0, delay_ms}) begin
              phase = bihv_pkg::PH_AWAIT_PERSIST;
            end
            v.ok = 1'b1;
          end
        end
        bihv_pkg::CMD_CONFIRM: begin
          if (phase != bihv_pkg::PH_AWAIT_PERSIST) begin
            v.ok = (phase == bihv_pkg::PH_CONFIRMED);
          end else begin
            v.confirm_request = 1'b1;
            if (c.action_ok) begin
              phase = bihv_pkg::PH_CONFIRMED;
              fault = bihv_pkg::ERR_NONE;
              v.ok  = 1'b1;
            end else begin
              phase = bihv_pkg::PH_PLAT_ERR;
              fault = bihv_pkg::ERR_CONFIRM;
            end
          end
        end
        default: begin
        end
      endcase
      v.phase        = phase;
      v.error_code   = fault;
      v.remaining_ms = window_left(c.now_ms);
      verdicts_due.push_back(v);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(bihv_pkg::out_item_t got);
      bihv_pkg::out_item_t want;
      if (verdicts_due.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      compare("ok", 64'(want.ok), 64'(got.ok));
      compare("phase", 64'(want.phase), 64'(got.phase));
      compare("error_code", 64'(want.error_code), 64'(got.error_code));
      compare("rollback_request", 64'(want.rollback_request), 64'(got.rollback_request));
      compare("confirm_request", 64'(want.confirm_request), 64'(got.confirm_request));
      compare("remaining_ms", 64'(want.remaining_ms), 64'(got.remaining_ms));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [31:0]         cfg_data    = '0;
  logic                in_valid    = 1'b0;
  bihv_pkg::in_item_t  in_data     = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  bihv_pkg::out_item_t out_data_o;

  verdict_ledger board;
  int unsigned   snd_idle  = 38;
  int unsigned   rcv_idle  = 59;
  int unsigned   hold_asks = 0;
  int unsigned   hold_seen = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycles    = 0;
  int unsigned   items_sent = 0;

  boot_image_health_validator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("boot_image_health_validator_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) board.check_verdict(out_data_o);
  end

  function automatic bihv_pkg::in_item_t make_cmd(logic [1:0] command, logic [63:0] now,
                                                  bit present, bit read_ok, logic [2:0] img,
                                                  bit gates, bit hard, bit act);
    bihv_pkg::in_item_t c;
    c.command          = command;
    c.now_ms           = now;
    c.platform_present = present;
    c.image_read_ok    = read_ok;
    c.image_state      = img;
    c.gates_ready      = gates;
    c.hard_failure     = hard;
    c.action_ok        = act;
    return c;
  endfunction

  function automatic bihv_pkg::in_item_t noise_cmd();
    bihv_pkg::in_item_t c;
    c.command          = 2'($urandom);
    c.now_ms           = {$urandom, $urandom};
    c.platform_present = 1'($urandom);
    c.image_read_ok    = 1'($urandom);
    c.image_state      = 3'($urandom);
    c.gates_ready      = 1'($urandom);
    c.hard_failure     = 1'($urandom);
    c.action_ok        = 1'($urandom);
    return c;
  endfunction

  function automatic logic [63:0] time_step(logic [31:0] delay);
    if ($urandom_range(99) < 6) return {$urandom, $urandom};
    return 64'($urandom_range(0, delay / 3 + 1));
  endfunction

  task automatic send_command(input bihv_pkg::in_item_t c);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(negedge clk_i); while (!in_ready_o);
    board.note_command(c);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.verdicts_due.size() != 0);
  endtask

  task automatic write_delay(input logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    board.delay_ms = value;
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_session();
    logic [63:0]        now;
    bihv_pkg::in_item_t c;
    int                 polls;
    now = {$urandom, $urandom};
    if ($urandom_range(3) == 0) now = '1 - 64'($urandom_range(0, 4000));
    c = noise_cmd();
    c.command          = bihv_pkg::CMD_START;
    c.now_ms           = now;
    c.platform_present = ($urandom_range(19) != 0);
    c.image_read_ok    = ($urandom_range(19) != 0);
    if ($urandom_range(9) < 8) c.image_state = bihv_pkg::IMG_PENDING;
    send_command(c);
    polls = $urandom_range(2, 12);
    for (int k = 0; k < polls; k++) begin
      c = noise_cmd();
      c.command = ($urandom_range(9) == 0) ? bihv_pkg::CMD_CONFIRM : bihv_pkg::CMD_POLL;
      if (board.window_open && $urandom_range(6) == 0)
        now = board.healthy_since + {32'd0, board.delay_ms} - 64'($urandom_range(0, 1));
      else
        now = now + time_step(board.delay_ms);
      c.now_ms       = now;
      c.gates_ready  = ($urandom_range(9) != 0);
      c.hard_failure = ($urandom_range(29) == 0);
      c.action_ok    = ($urandom_range(9) != 0);
      send_command(c);
    end
    c = noise_cmd();
    c.command   = bihv_pkg::CMD_CONFIRM;
    now         = now + time_step(board.delay_ms);
    c.now_ms    = now;
    c.action_ok = ($urandom_range(7) != 0);
    send_command(c);
    if ($urandom_range(2) == 0) begin
      c = noise_cmd();
      c.command = ($urandom_range(1) == 0) ? bihv_pkg::CMD_POLL : bihv_pkg::CMD_CONFIRM;
      c.now_ms  = now + time_step(board.delay_ms);
      send_command(c);
    end
  endtask

  task automatic run_directed();
    logic [63:0] top;
    top = '1;
    send_command(make_cmd(bihv_pkg::CMD_POLL, '0, 1, 1, bihv_pkg::IMG_PENDING, 1, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_CONFIRM, top, 1, 1, bihv_pkg::IMG_PENDING, 1, 0, 1));
    send_command(make_cmd(CMD_UNUSED, top, 1, 1, bihv_pkg::IMG_PENDING, 1, 1, 1));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd5, 0, 1, bihv_pkg::IMG_PENDING, 1, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd6, 1, 0, bihv_pkg::IMG_PENDING, 1, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd7, 1, 1, bihv_pkg::IMG_NEW, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd8, 1, 1, bihv_pkg::IMG_INVALID, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd9, 1, 1, bihv_pkg::IMG_ABORTED, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd10, 1, 1, IMG_SPARE_LO, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd11, 1, 1, IMG_SPARE_HI, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd12, 1, 1, bihv_pkg::IMG_UNDEFINED,
                          0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd13, 0, 0, bihv_pkg::IMG_NEW, 1, 1, 0));
    send_command(make_cmd(bihv_pkg::CMD_CONFIRM, 64'd14, 0, 0, bihv_pkg::IMG_NEW, 1, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd15, 1, 1, bihv_pkg::IMG_VALID, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, top, 1, 1, bihv_pkg::IMG_PENDING, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, top, 0, 0, bihv_pkg::IMG_NEW, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, top - 64'd15, 0, 0, bihv_pkg::IMG_NEW,
                          1, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd59983, 0, 0, bihv_pkg::IMG_NEW, 1, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd59984, 0, 0, bihv_pkg::IMG_NEW, 1, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd59985, 1, 1, bihv_pkg::IMG_NEW, 0, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_CONFIRM, 64'd59986, 0, 0, bihv_pkg::IMG_NEW,
                          0, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd59987, 0, 0, bihv_pkg::IMG_NEW, 1, 0, 1));
    send_command(make_cmd(bihv_pkg::CMD_CONFIRM, 64'd59988, 0, 0, bihv_pkg::IMG_NEW,
                          1, 0, 0));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd100, 1, 1, bihv_pkg::IMG_PENDING,
                          1, 1, 0));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd101, 0, 0, bihv_pkg::IMG_NEW, 1, 1, 1));
    send_command(make_cmd(bihv_pkg::CMD_START, 64'd102, 1, 1, bihv_pkg::IMG_PENDING,
                          1, 1, 1));
    send_command(make_cmd(bihv_pkg::CMD_POLL, 64'd103, 0, 0, bihv_pkg::IMG_NEW, 0, 1, 0));
  endtask

  initial begin
    logic [31:0] delays[6];
    int unsigned target;
    bit          paused;
    board  = new();
    paused = 1'b0;
    delays[0] = 32'd0;
    delays[1] = 32'hFFFF_FFFF;
    delays[2] = 32'd1;
    delays[3] = 32'($urandom_range(2, 5000));
    delays[4] = bihv_pkg::DelayResetMs;
    delays[5] = 32'd250;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        snd_idle = 59;
        rcv_idle <= 38;
      end
      if (p == 4) begin
        snd_idle = 0;
        rcv_idle <= 0;
      end
      write_delay(delays[p]);
      if (p == 1 || p == 4) hold_asks <= hold_asks + 1;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 4)) send_command(noise_cmd());
        end else begin
          run_session();
        end
        if (p == 3 && !paused && items_sent + 60 > target) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("boot_image_health_validator_tb: done, clean");
    end else begin
      $display("boot_image_health_validator_tb: done, errors");
    end
    $finish;
  end

endmodule
